[rtl/urcd_pkg.sv]
package urcd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_ECHO_ENABLE = 3'd4;

    localparam logic [2:0] V_SHORT   = 3'd0;
    localparam logic [2:0] V_BADLEN  = 3'd1;
    localparam logic [2:0] V_BADSUM  = 3'd2;
    localparam logic [2:0] V_DELIVER = 3'd3;
    localparam logic [2:0] V_ECHO    = 3'd4;
    localparam logic [2:0] V_NOMATCH = 3'd5;

    localparam logic [15:0] ECHO_PORT = 16'd7;
    localparam logic [15:0] PROTO_UDP = 16'd17;
    localparam logic [15:0] UDP_HDR   = 16'd8;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [16:0] sum;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] udp_len;
        logic [15:0] chk;
        logic [7:0]  pend;
        logic [15:0] total;
        logic [5:0]  hlen;
    } packet_t;

    function automatic logic [16:0] fold_add(input logic [16:0] acc, input logic [15:0] word);
        logic [17:0] s;
        s = {1'b0, acc} + {2'b00, word};
        return {1'b0, s[15:0]} + {15'd0, s[17:16]};
    endfunction

endpackage

[rtl/urcd_capture.sv]
module urcd_capture
    import urcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [5:0]  header_bytes,
    output logic        pkt_valid,
    input  logic        pkt_ready,
    output packet_t     pkt
);

    logic [15:0] count_reg, count_next;
    logic [16:0] sum_reg, sum_next;
    logic [7:0]  pend_reg, pend_next;
    logic [5:0]  hlen_reg, hlen_next;
    logic [31:0] src_ip_reg, src_ip_next;
    logic [31:0] dst_ip_reg, dst_ip_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;
    logic [15:0] ulen_reg, ulen_next;
    logic [15:0] chk_reg, chk_next;
    logic [15:0] off;
    logic        accept;
    logic        pkt_valid_reg;
    packet_t     pkt_reg;

    assign byte_ready = !pkt_valid_reg || pkt_ready;
    assign accept     = byte_valid && byte_ready;
    assign pkt_valid  = pkt_valid_reg;
    assign pkt        = pkt_reg;
    assign off        = count_reg - {10'd0, hlen_next};

    always_comb
    begin
        count_next  = count_reg;
        sum_next    = sum_reg;
        pend_next   = pend_reg;
        src_ip_next = src_ip_reg;
        dst_ip_next = dst_ip_reg;
        sport_next  = sport_reg;
        dport_next  = dport_reg;
        ulen_next   = ulen_reg;
        chk_next    = chk_reg;
        hlen_next   = (count_reg == 16'd0) ? header_bytes : hlen_reg;
        if (count_reg != COUNT_MAX)
        begin
            count_next = count_reg + 16'd1;
            if (count_reg >= 16'd12 && count_reg < 16'd16)
            begin
                src_ip_next = {src_ip_reg[23:0], data_byte};
            end
            else if (count_reg >= 16'd16 && count_reg < 16'd20)
            begin
                dst_ip_next = {dst_ip_reg[23:0], data_byte};
            end
            if (count_reg >= {10'd0, hlen_next})
            begin
                if (off < 16'd2)
                begin
                    sport_next = {sport_reg[7:0], data_byte};
                end
                else if (off < 16'd4)
                begin
                    dport_next = {dport_reg[7:0], data_byte};
                end
                else if (off < 16'd6)
                begin
                    ulen_next = {ulen_reg[7:0], data_byte};
                end
                else if (off < 16'd8)
                begin
                    chk_next = {chk_reg[7:0], data_byte};
                end
                if (off < 16'd6 || off < ulen_next)
                begin
                    if (!off[0])
                    begin
                        pend_next = data_byte;
                    end
                    else
                    begin
                        sum_next = fold_add(sum_reg, {pend_reg, data_byte});
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            pend_reg      <= '0;
            hlen_reg      <= '0;
            src_ip_reg    <= '0;
            dst_ip_reg    <= '0;
            sport_reg     <= '0;
            dport_reg     <= '0;
            ulen_reg      <= '0;
            chk_reg       <= '0;
            pkt_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (last_byte)
                begin
                    count_reg  <= '0;
                    sum_reg    <= '0;
                    pend_reg   <= '0;
                    hlen_reg   <= '0;
                    src_ip_reg <= '0;
                    dst_ip_reg <= '0;
                    sport_reg  <= '0;
                    dport_reg  <= '0;
                    ulen_reg   <= '0;
                    chk_reg    <= '0;
                end
                else
                begin
                    count_reg  <= count_next;
                    sum_reg    <= sum_next;
                    pend_reg   <= pend_next;
                    hlen_reg   <= hlen_next;
                    src_ip_reg <= src_ip_next;
                    dst_ip_reg <= dst_ip_next;
                    sport_reg  <= sport_next;
                    dport_reg  <= dport_next;
                    ulen_reg   <= ulen_next;
                    chk_reg    <= chk_next;
                end
            end
            if (byte_ready)
            begin
                pkt_valid_reg <= accept && last_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            pkt_reg.sum     <= sum_next;
            pkt_reg.src_ip  <= src_ip_next;
            pkt_reg.dst_ip  <= dst_ip_next;
            pkt_reg.sport   <= sport_next;
            pkt_reg.dport   <= dport_next;
            pkt_reg.udp_len <= ulen_next;
            pkt_reg.chk     <= chk_next;
            pkt_reg.pend    <= pend_next;
            pkt_reg.total   <= count_next;
            pkt_reg.hlen    <= hlen_next;
        end
    end

endmodule

[rtl/urcd_judge.sv]
module urcd_judge
    import urcd_pkg::*;
#(
    parameter int BIND_SLOTS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pkt_valid,
    output logic        pkt_ready,
    input  packet_t     pkt,
    input  logic [15:0] slot_port [BIND_SLOTS],
    input  logic        echo_enable,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [2:0]  verdict,
    output logic [1:0]  slot_index,
    output logic [31:0] source_address,
    output logic [15:0] source_port,
    output logic [15:0] dest_port,
    output logic [15:0] payload_bytes
);

    typedef struct packed {
        logic [16:0] sum;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] udp_len;
        logic [15:0] chk;
        logic [7:0]  pend;
        logic        short_pkt;
        logic        bad_len;
        logic        echo_hit;
        logic        slot_hit;
        logic [1:0]  slot;
    } stage_t;

    stage_t      s1_reg, s2_reg, s3_reg;
    stage_t      s1_next, s2_next, s3_next;
    logic        v1_reg, v2_reg, v3_reg, vo_reg;
    logic        rdy1, rdy2, rdy3, rdyo;
    logic [16:0] total_minus_h;
    logic [16:0] pad_sum;
    logic [16:0] final_sum;
    logic        sum_bad;
    logic [2:0]  verdict_next;
    logic [2:0]  verdict_reg;
    logic [1:0]  slot_reg;
    logic [31:0] src_reg;
    logic [15:0] sport_reg, dport_reg, payload_reg;

    assign rdyo      = !vo_reg || res_ready;
    assign rdy3      = !v3_reg || rdyo;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign pkt_ready = rdy1;

    assign total_minus_h = {1'b0, pkt.total} - {11'd0, pkt.hlen};

    always_comb
    begin
        s1_next.sum       = fold_add(fold_add(pkt.sum, pkt.src_ip[31:16]), pkt.src_ip[15:0]);
        s1_next.src_ip    = pkt.src_ip;
        s1_next.dst_ip    = pkt.dst_ip;
        s1_next.sport     = pkt.sport;
        s1_next.dport     = pkt.dport;
        s1_next.udp_len   = pkt.udp_len;
        s1_next.chk       = pkt.chk;
        s1_next.pend      = pkt.pend;
        s1_next.short_pkt = {1'b0, pkt.total} < ({11'd0, pkt.hlen} + {1'b0, UDP_HDR});
        s1_next.bad_len   = (pkt.udp_len < UDP_HDR) || ({1'b0, pkt.udp_len} > total_minus_h);
        s1_next.echo_hit  = 1'b0;
        s1_next.slot_hit  = 1'b0;
        s1_next.slot      = 2'd0;
    end

    always_comb
    begin
        s2_next     = s1_reg;
        s2_next.sum = fold_add(fold_add(s1_reg.sum, s1_reg.dst_ip[31:16]), s1_reg.dst_ip[15:0]);
        s2_next.echo_hit = echo_enable && (s1_reg.dport == ECHO_PORT);
        for (int i = BIND_SLOTS - 1; i >= 0; i--)
        begin
            if (slot_port[i] != 16'd0 && slot_port[i] == s1_reg.dport)
            begin
                s2_next.slot_hit = 1'b1;
                s2_next.slot     = 2'(i);
            end
        end
    end

    always_comb
    begin
        s3_next     = s2_reg;
        s3_next.sum = fold_add(fold_add(s2_reg.sum, PROTO_UDP), s2_reg.udp_len);
    end

    always_comb
    begin
        pad_sum   = s3_reg.udp_len[0] ? fold_add(s3_reg.sum, {s3_reg.pend, 8'd0}) : s3_reg.sum;
        final_sum = {1'b0, pad_sum[15:0]} + {16'd0, pad_sum[16]};
        sum_bad   = (s3_reg.chk != 16'd0) && (final_sum[15:0] != 16'hFFFF);
        if (s3_reg.short_pkt)
        begin
            verdict_next = V_SHORT;
        end
        else if (s3_reg.bad_len)
        begin
            verdict_next = V_BADLEN;
        end
        else if (sum_bad)
        begin
            verdict_next = V_BADSUM;
        end
        else if (s3_reg.echo_hit)
        begin
            verdict_next = V_ECHO;
        end
        else if (s3_reg.slot_hit)
        begin
            verdict_next = V_DELIVER;
        end
        else
        begin
            verdict_next = V_NOMATCH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= pkt_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdyo)
            begin
                vo_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3)
        begin
            s3_reg <= s3_next;
        end
        if (rdyo)
        begin
            verdict_reg <= verdict_next;
            slot_reg    <= (verdict_next == V_DELIVER) ? s3_reg.slot : 2'd0;
            if (verdict_next == V_SHORT || verdict_next == V_BADLEN)
            begin
                src_reg     <= '0;
                sport_reg   <= '0;
                dport_reg   <= '0;
                payload_reg <= '0;
            end
            else
            begin
                src_reg     <= s3_reg.src_ip;
                sport_reg   <= s3_reg.sport;
                dport_reg   <= s3_reg.dport;
                payload_reg <= s3_reg.udp_len - UDP_HDR;
            end
        end
    end

    assign res_valid      = vo_reg;
    assign verdict        = verdict_reg;
    assign slot_index     = slot_reg;
    assign source_address = src_reg;
    assign source_port    = sport_reg;
    assign dest_port      = dport_reg;
    assign payload_bytes  = payload_reg;

endmodule

[rtl/udp_receive_check_demux_top.sv]
// Checks UDP datagrams carried in IPv4 packets and sorts them by destination port. Packet
// bytes enter one word per clock cycle while s_tready is high, header first; the byte
// capture stage updates its running one's-complement sum with one 16-bit end-around add
// per pair of bytes. On the word marked last the packet's state is handed to a four-stage
// judging pipeline (three pseudo-header sum stages and the verdict register), and the
// verdict word is presented once the packet has passed those stages. Input is held off
// only when that pipeline is full and the output word is not being taken.
module udp_receive_check_demux_top
    import urcd_pkg::*;
#(
    parameter int BIND_SLOTS = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [15:0]            s_tdata,   // data_byte[7:0], header_bytes[13:8], zero
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // verdict[2:0], slot_index[4:3], source_address[36:5], source_port[52:37],
    // dest_port[68:53], payload_bytes[84:69], zero
    output logic [87:0]            m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    logic [15:0] slot_port_reg [BIND_SLOTS];
    logic        echo_reg;
    logic        pkt_valid;
    logic        pkt_ready;
    packet_t     pkt;
    logic [2:0]  verdict;
    logic [1:0]  slot_index;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] payload_bytes;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BIND_SLOTS; i++)
            begin
                slot_port_reg[i] <= '0;
            end
            echo_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < BIND_SLOTS; i++)
            begin
                if (cfg_index == CFG_INDEX_W'(i))
                begin
                    slot_port_reg[i] <= cfg_data;
                end
            end
            if (cfg_index == REG_ECHO_ENABLE)
            begin
                echo_reg <= cfg_data[0];
            end
        end
    end

    urcd_capture u_capture
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (s_tvalid),
        .byte_ready   (s_tready),
        .data_byte    (s_tdata[7:0]),
        .last_byte    (s_tlast),
        .header_bytes (s_tdata[13:8]),
        .pkt_valid    (pkt_valid),
        .pkt_ready    (pkt_ready),
        .pkt          (pkt)
    );

    urcd_judge #(
        .BIND_SLOTS (BIND_SLOTS)
    ) u_judge
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .pkt_valid      (pkt_valid),
        .pkt_ready      (pkt_ready),
        .pkt            (pkt),
        .slot_port      (slot_port_reg),
        .echo_enable    (echo_reg),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .verdict        (verdict),
        .slot_index     (slot_index),
        .source_address (source_address),
        .source_port    (source_port),
        .dest_port      (dest_port),
        .payload_bytes  (payload_bytes)
    );

    assign m_tdata = {3'd0, payload_bytes, dest_port, source_port, source_address,
                      slot_index, verdict};

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input held off while the output word is free");

    a_slot_only_on_delivery: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && verdict != V_DELIVER) |-> (slot_index == 2'd0))
        else $error("slot index set on a word that is not a delivery");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && verdict == V_DELIVER) |-> (int'(slot_index) < BIND_SLOTS))
        else $error("delivery to a slot that is not searched");

    a_rejects_are_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (verdict == V_SHORT || verdict == V_BADLEN))
            |-> (source_address == 32'd0 && source_port == 16'd0 &&
                 dest_port == 16'd0 && payload_bytes == 16'd0))
        else $error("rejected packet carries header fields");

endmodule
